// File: hw/rtl/timestamp_rate_calibrator_core_defines.svh
// assertion macros for the timestamp rate calibrator
`ifndef TIMESTAMP_RATE_CALIBRATOR_CORE_DEFINES_SVH
`define TIMESTAMP_RATE_CALIBRATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define TRC_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("trc assertion failed");
// antecedent in one cycle implies consequent in the next
`define TRC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trc assertion failed");
`else
`define TRC_ASSERT(name, prop)
`define TRC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: hw/rtl/trc_pkg.sv
// shared types and constants of the timestamp rate calibrator
package trc_pkg;

    localparam int STAMP_WIDTH       = 64;
    localparam int RATE_WIDTH        = 26;
    localparam int STAMP_FIELD_WIDTH = 64;
    localparam int UPTIME_WIDTH      = 64;
    localparam int STATUS_WIDTH      = 3;
    localparam int WIN_WIDTH         = 10;
    localparam int BUDGET_WIDTH      = 32;
    localparam int POLL_WIDTH        = BUDGET_WIDTH + 1;
    localparam int CFG_RATE_WIDTH    = 26;
    localparam int BAND_WIDTH        = (RATE_WIDTH < CFG_RATE_WIDTH) ? RATE_WIDTH
                                                                     : CFG_RATE_WIDTH;
    localparam int DIV_WIDTH         = (RATE_WIDTH > WIN_WIDTH) ? RATE_WIDTH : WIN_WIDTH;
    localparam int CNT_WIDTH         = $clog2(STAMP_WIDTH + 1);
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int CFG_INDEX_WIDTH   = 2;
    localparam int IN_USER_WIDTH     = 3;
    localparam int OUT_FIELDS_WIDTH  = STATUS_WIDTH + 1 + CFG_RATE_WIDTH + UPTIME_WIDTH;
    localparam int OUT_DATA_WIDTH    = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WINDOW   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BUDGET   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_MIN = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_MAX = 2'd3;

    localparam logic [WIN_WIDTH-1:0]    WINDOW_RESET   = WIN_WIDTH'(50);
    localparam logic [BUDGET_WIDTH-1:0] BUDGET_RESET   = BUDGET_WIDTH'(200000000);
    localparam logic [BAND_WIDTH-1:0]   RATE_MIN_RESET = BAND_WIDTH'(100000);
    localparam logic [BAND_WIDTH-1:0]   RATE_MAX_RESET = BAND_WIDTH'(50000000);

    typedef enum logic [STATUS_WIDTH-1:0] {
        PH_IDLE    = 3'd0,
        PH_MEAS    = 3'd1,
        PH_CAL     = 3'd2,
        PH_TIMEOUT = 3'd3,
        PH_NOADV   = 3'd4,
        PH_BAND    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_CALDIV,
        SEQ_QCHK,
        SEQ_QDIV,
        SEQ_PUSH
    } seq_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hw/rtl/trc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module trc_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [trc_pkg::STAMP_WIDTH-1:0]      dividend,
    input  logic [trc_pkg::DIV_WIDTH-1:0]        divisor,
    output trc_pkg::div_stat_t                   stat,
    output logic [trc_pkg::STAMP_WIDTH-1:0]      quotient
);

    logic [trc_pkg::STAMP_WIDTH-1:0] quo_reg;
    logic [trc_pkg::DIV_WIDTH-1:0]   rem_reg;
    logic [trc_pkg::DIV_WIDTH-1:0]   dsr_reg;
    logic [trc_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [trc_pkg::DIV_WIDTH:0]     trial;
    logic                            fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[trc_pkg::STAMP_WIDTH-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= trc_pkg::CNT_WIDTH'(trc_pkg::STAMP_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - trc_pkg::CNT_WIDTH'(1);
                if (cnt_reg == trc_pkg::CNT_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[trc_pkg::STAMP_WIDTH-2:0], fits};
            if (fits)
                rem_reg <= trc_pkg::DIV_WIDTH'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[trc_pkg::DIV_WIDTH-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: hw/rtl/timestamp_rate_calibrator_core.sv
// top level of the timestamp rate calibrator
// Each accepted item gives exactly one result item. A plain item (start, poll,
// query while not calibrated) goes through the EVAL, QCHK and PUSH states into
// the output register, and the next item can be taken once the sequencer is back
// in IDLE. The item whose ref_done closes the measuring window also runs one
// division of the elapsed stamps by window_ms, and an answered uptime query runs
// one division of (stamp - boot stamp) by the rate; each division goes through
// the shared bit-serial divider at one quotient bit a cycle. One item is worked
// on at a time; a finished result waits in the output register while the next
// item is taken in, and a result that is still waiting there when the next one
// is ready holds off the input. Configuration is a plain write port: cfg_we with
// cfg_index 0 window_ms, 1 poll_budget, 2 rate_min, 3 rate_max. Once calibrated
// the block stays calibrated until reset.
`include "timestamp_rate_calibrator_core_defines.svh"

module timestamp_rate_calibrator_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // config write port
    input  logic                                   cfg_we,
    input  logic [trc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [trc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [trc_pkg::STAMP_FIELD_WIDTH-1:0]  s_tdata,   // stamp
    input  logic [trc_pkg::IN_USER_WIDTH-1:0]      s_tuser,   // start_req, ref_done, query
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [trc_pkg::OUT_DATA_WIDTH-1:0]     m_tdata    // status, gate, rate, uptime_ms
);

    localparam int SW = trc_pkg::STAMP_WIDTH;

    // configuration registers
    logic [trc_pkg::WIN_WIDTH-1:0]    window_reg;
    logic [trc_pkg::BUDGET_WIDTH-1:0] budget_reg;
    logic [trc_pkg::BAND_WIDTH-1:0]   rate_min_reg;
    logic [trc_pkg::BAND_WIDTH-1:0]   rate_max_reg;

    // calibration state
    trc_pkg::phase_t                  phase_reg;
    logic [SW-1:0]                    start_stamp_reg;
    logic [trc_pkg::POLL_WIDTH-1:0]   poll_reg;
    logic [trc_pkg::RATE_WIDTH-1:0]   ticks_reg;
    logic [SW-1:0]                    boot_reg;

    // sequencer and item latches
    trc_pkg::seq_t                    seq_reg, seq_next;
    logic [SW-1:0]                    now_reg;
    logic                             start_req_reg;
    logic                             ref_done_reg;
    logic                             query_reg;
    logic [SW-1:0]                    up_reg;

    // output register
    logic                                 m_tvalid_reg;
    logic [trc_pkg::STATUS_WIDTH-1:0]     out_status_reg;
    logic                                 out_gate_reg;
    logic [trc_pkg::CFG_RATE_WIDTH-1:0]   out_rate_reg;
    logic [trc_pkg::UPTIME_WIDTH-1:0]     out_up_reg;

    // shared divider
    logic                             div_start;
    logic [trc_pkg::DIV_WIDTH-1:0]    div_divisor;
    trc_pkg::div_stat_t               div_stat;
    logic [SW-1:0]                    div_quo;

    // datapath helpers
    logic [SW-1:0]                    subtrahend;
    logic [SW:0]                      diff_ext;
    logic                             ahead;
    logic [trc_pkg::POLL_WIDTH-1:0]   poll_inc;
    logic                             cal_go;
    logic                             q_go;
    logic                             band_ok;
    logic                             out_free;
    logic                             out_load;
    logic                             in_take;

    // one subtractor serves both the window length and the uptime
    assign subtrahend = (seq_reg == trc_pkg::SEQ_QCHK) ? boot_reg : start_stamp_reg;
    assign diff_ext   = {1'b0, now_reg} - {1'b0, subtrahend};
    assign ahead      = !diff_ext[SW] && (diff_ext[SW-1:0] != '0);

    assign poll_inc = poll_reg + trc_pkg::POLL_WIDTH'(1);

    // window closes with real progress: go divide
    assign cal_go = (phase_reg == trc_pkg::PH_MEAS) && ref_done_reg && ahead;

    // query answered only when calibrated with a usable rate
    assign q_go = query_reg && (phase_reg == trc_pkg::PH_CAL) && (ticks_reg != '0) && ahead;

    // full-width band check so a huge quotient cannot wrap into the band
    assign band_ok = (div_quo >= SW'(rate_min_reg)) && (div_quo <= SW'(rate_max_reg));

    assign out_free = !m_tvalid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= trc_pkg::WINDOW_RESET;
            budget_reg   <= trc_pkg::BUDGET_RESET;
            rate_min_reg <= trc_pkg::RATE_MIN_RESET;
            rate_max_reg <= trc_pkg::RATE_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                trc_pkg::REG_WINDOW:   window_reg   <= cfg_data[trc_pkg::WIN_WIDTH-1:0];
                trc_pkg::REG_BUDGET:   budget_reg   <= cfg_data[trc_pkg::BUDGET_WIDTH-1:0];
                trc_pkg::REG_RATE_MIN: rate_min_reg <= cfg_data[trc_pkg::BAND_WIDTH-1:0];
                trc_pkg::REG_RATE_MAX: rate_max_reg <= cfg_data[trc_pkg::BAND_WIDTH-1:0];
                default:               ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            trc_pkg::SEQ_IDLE:
                if (s_tvalid)
                    seq_next = trc_pkg::SEQ_EVAL;
            trc_pkg::SEQ_EVAL:
                seq_next = cal_go ? trc_pkg::SEQ_CALDIV : trc_pkg::SEQ_QCHK;
            trc_pkg::SEQ_CALDIV:
                if (div_stat.done)
                    seq_next = trc_pkg::SEQ_QCHK;
            trc_pkg::SEQ_QCHK:
                seq_next = q_go ? trc_pkg::SEQ_QDIV : trc_pkg::SEQ_PUSH;
            trc_pkg::SEQ_QDIV:
                if (div_stat.done)
                    seq_next = trc_pkg::SEQ_PUSH;
            trc_pkg::SEQ_PUSH:
                if (out_free)
                    seq_next = trc_pkg::SEQ_IDLE;
            default:
                seq_next = trc_pkg::SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_take     = 1'b0;
        div_start   = 1'b0;
        div_divisor = '0;
        out_load    = 1'b0;
        unique case (seq_reg)
            trc_pkg::SEQ_IDLE:
                in_take = 1'b1;
            trc_pkg::SEQ_EVAL:
            begin
                div_start = cal_go;
                // zero window divides as one
                div_divisor = (window_reg == '0) ? trc_pkg::DIV_WIDTH'(1)
                                                 : trc_pkg::DIV_WIDTH'(window_reg);
            end
            trc_pkg::SEQ_QCHK:
            begin
                div_start   = q_go;
                div_divisor = trc_pkg::DIV_WIDTH'(ticks_reg);
            end
            trc_pkg::SEQ_PUSH:
                out_load = out_free;
            default:
                ;
        endcase
    end

    assign s_tready = in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= trc_pkg::SEQ_IDLE;
        else
            seq_reg <= seq_next;
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (in_take && s_tvalid)
        begin
            now_reg       <= SW'(s_tdata);
            start_req_reg <= s_tuser[0];
            ref_done_reg  <= s_tuser[1];
            query_reg     <= s_tuser[2];
        end
        if (seq_reg == trc_pkg::SEQ_QCHK && !q_go)
            up_reg <= '0;
        else if (seq_reg == trc_pkg::SEQ_QDIV && div_stat.done)
            up_reg <= div_quo;
    end

    // calibration state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= trc_pkg::PH_IDLE;
            start_stamp_reg <= '0;
            poll_reg        <= '0;
            ticks_reg       <= '0;
            boot_reg        <= '0;
        end
        else if (seq_reg == trc_pkg::SEQ_EVAL)
        begin
            if (phase_reg == trc_pkg::PH_MEAS)
            begin
                if (ref_done_reg)
                begin
                    if (!ahead)
                        phase_reg <= trc_pkg::PH_NOADV;
                end
                else
                begin
                    poll_reg <= poll_inc;
                    if (poll_inc > trc_pkg::POLL_WIDTH'(budget_reg))
                        phase_reg <= trc_pkg::PH_TIMEOUT;
                end
            end
            else if (phase_reg != trc_pkg::PH_CAL && start_req_reg)
            begin
                start_stamp_reg <= now_reg;
                poll_reg        <= '0;
                phase_reg       <= trc_pkg::PH_MEAS;
            end
        end
        else if (seq_reg == trc_pkg::SEQ_CALDIV && div_stat.done)
        begin
            if (band_ok)
            begin
                ticks_reg <= trc_pkg::RATE_WIDTH'(div_quo);
                boot_reg  <= start_stamp_reg;
                phase_reg <= trc_pkg::PH_CAL;
            end
            else
                phase_reg <= trc_pkg::PH_BAND;
        end
    end

    // output register, loaded when empty or while the previous result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= phase_reg;
            out_gate_reg   <= (phase_reg == trc_pkg::PH_MEAS);
            out_rate_reg   <= trc_pkg::CFG_RATE_WIDTH'(ticks_reg);
            out_up_reg     <= trc_pkg::UPTIME_WIDTH'(up_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = trc_pkg::OUT_DATA_WIDTH'({out_up_reg, out_rate_reg,
                                                out_gate_reg, out_status_reg});

    trc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_ext[SW-1:0]),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // divider only runs for the two division steps
    `TRC_ASSERT(a_div_owner, !div_stat.busy || seq_reg == trc_pkg::SEQ_CALDIV || seq_reg == trc_pkg::SEQ_QDIV)
    // calibration is sticky
    `TRC_ASSERT_NEXT(a_cal_sticky, phase_reg == trc_pkg::PH_CAL, phase_reg == trc_pkg::PH_CAL)
    // a nonzero rate exists only once calibrated
    `TRC_ASSERT(a_rate_cal, ticks_reg == '0 || phase_reg == trc_pkg::PH_CAL)
    // no uptime is reported while measuring
    `TRC_ASSERT(a_gate_up, !(m_tvalid_reg && out_gate_reg) || out_up_reg == '0)

endmodule
